### hdl/qgpg_pkg.sv
// Shared types, constants and helpers for the quadruped gait phase generator.
`default_nettype none
package qgpg_pkg;

  // Field widths
  localparam int AmountW   = 40;
  localparam int FreqW     = 24;
  localparam int DutyW     = 16;
  localparam int PhaseW    = 16;
  localparam int AccW      = 32;
  localparam int ProgW     = 17;
  localparam int LegW      = 2;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 24;
  localparam int OutDataW  = 56;

  // Clamp limits
  localparam logic [FreqW-1:0] FreqMin = 24'd66;
  localparam logic [DutyW-1:0] DutyMin = 16'd3277;
  localparam logic [DutyW-1:0] DutyMax = 16'd62259;

  // Leg sequencing
  localparam int NumLegs = 4;
  localparam logic [LegW-1:0] LastLeg = LegW'(NumLegs - 1);

  // Divider: quotient bits retired per cycle and divider steps per quotient
  localparam int DivBitsPerCycle = 4;
  localparam int DivSteps        = PhaseW / DivBitsPerCycle;
  localparam int DivStepW        = $clog2(DivSteps);

  // Base-phase queue between front and back
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);

  // Config register indexes
  localparam logic [CfgIdxW-1:0] CfgGaitMode = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFreq     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDuty     = 2'd2;

  // Config reset values
  localparam logic [FreqW-1:0] FreqReset = 24'd65536;
  localparam logic [DutyW-1:0] DutyReset = 16'd32768;

  typedef enum logic [1:0] {
    GAIT_WALK  = 2'd0,
    GAIT_TROT  = 2'd1,
    GAIT_PACE  = 2'd2,
    GAIT_BOUND = 2'd3
  } gait_e;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_MUL,
    FR_SUM,
    FR_COMMIT
  } front_state_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LEG,
    BK_DIV,
    BK_OUT
  } back_state_e;

  // Queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // One leg result, leg in the lowest bits
  typedef struct packed {
    logic [ProgW-1:0]  stance_frac;
    logic [ProgW-1:0]  swing_frac;
    logic              swing_now;
    logic [PhaseW-1:0] phase;
    logic [LegW-1:0]   leg;
  } leg_res_t;

  localparam int ResW = $bits(leg_res_t);
  localparam int OutPadW = OutDataW - ResW;

  // Leg offset in quarter cycles for a gait
  function automatic logic [1:0] leg_quarter(input gait_e mode, input logic [LegW-1:0] leg);
    logic [7:0] row;  // leg 3 in top bits
    begin
      unique case (mode)
        GAIT_WALK:  row = {2'd1, 2'd3, 2'd2, 2'd0};
        GAIT_TROT:  row = {2'd0, 2'd2, 2'd2, 2'd0};
        GAIT_PACE:  row = {2'd2, 2'd0, 2'd2, 2'd0};
        GAIT_BOUND: row = {2'd2, 2'd2, 2'd0, 2'd0};
        default:    row = 8'd0;
      endcase
      return row[{leg, 1'b0} +: 2];
    end
  endfunction

endpackage
`default_nettype wire

### hdl/qgpg_front.sv
// Front end: takes input words, scales time by frequency, updates the phase accumulator.
`default_nettype none
module qgpg_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              in_op_i,
  input  wire logic [qgpg_pkg::AmountW-1:0]      in_amount_i,
  input  wire logic [qgpg_pkg::FreqW-1:0]        freq_i,
  input  wire qgpg_pkg::q_stat_t                 q_stat_i,
  output logic                                   push_o,
  output logic [qgpg_pkg::PhaseW-1:0]            push_data_o
);

  localparam int HalfW = qgpg_pkg::AmountW / 2;
  localparam int ProdW = HalfW + qgpg_pkg::FreqW;

  qgpg_pkg::front_state_e state_q, state_d;
  logic [qgpg_pkg::AccW-1:0]    acc_q, acc_d;
  logic [qgpg_pkg::AccW-1:0]    acc_sum;
  qgpg_pkg::op_e                op_q;
  logic [qgpg_pkg::AmountW-1:0] amt_q;
  logic [ProdW-1:0]             p_lo_q;
  logic signed [ProdW:0]        p_hi_q;
  logic [qgpg_pkg::AccW-1:0]    scaled_q;
  logic [qgpg_pkg::AccW+3:0]    sum36;

  // Low 36 bits of the full product; bits [35:4] are the phase step
  assign sum36   = {p_hi_q[qgpg_pkg::AccW+3-HalfW:0], {HalfW{1'b0}}}
                 + p_lo_q[qgpg_pkg::AccW+3:0];
  assign acc_sum = acc_q + scaled_q;

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    in_ready_o  = 1'b0;
    push_o      = 1'b0;
    push_data_o = acc_sum[qgpg_pkg::AccW-1 -: qgpg_pkg::PhaseW];
    unique case (state_q)
      qgpg_pkg::FR_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = qgpg_pkg::FR_MUL;
      end
      qgpg_pkg::FR_MUL: state_d = qgpg_pkg::FR_SUM;
      qgpg_pkg::FR_SUM: state_d = qgpg_pkg::FR_COMMIT;
      qgpg_pkg::FR_COMMIT: begin
        if (op_q == qgpg_pkg::OP_SET) begin
          acc_d   = scaled_q;
          state_d = qgpg_pkg::FR_IDLE;
        end else if (!q_stat_i.full) begin
          acc_d   = acc_sum;
          push_o  = 1'b1;
          state_d = qgpg_pkg::FR_IDLE;
        end
      end
      default: state_d = qgpg_pkg::FR_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qgpg_pkg::FR_IDLE;
      acc_q   <= '0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
    end
  end

  // Datapath: amount split in halves, two narrow multiplies, then one add
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q  <= qgpg_pkg::op_e'(in_op_i);
      amt_q <= in_amount_i;
    end
    p_lo_q   <= amt_q[HalfW-1:0] * freq_i;
    p_hi_q   <= $signed(amt_q[qgpg_pkg::AmountW-1:HalfW]) * $signed({1'b0, freq_i});
    scaled_q <= sum36[qgpg_pkg::AccW+3:4];
  end

endmodule
`default_nettype wire

### hdl/qgpg_queue.sv
// Short queue of base phases between front and back.
`default_nettype none
module qgpg_queue (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            push_i,
  input  wire logic [qgpg_pkg::PhaseW-1:0]     push_data_i,
  input  wire logic                            pop_i,
  output logic [qgpg_pkg::PhaseW-1:0]          pop_data_o,
  output qgpg_pkg::q_stat_t                    stat_o
);

  logic [qgpg_pkg::PhaseW-1:0] mem_q [qgpg_pkg::QDepth];
  logic [qgpg_pkg::QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [qgpg_pkg::QPtrW:0]    count_q;

  assign stat_o.full  = (count_q == (qgpg_pkg::QPtrW+1)'(qgpg_pkg::QDepth));
  assign stat_o.empty = (count_q == '0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule
`default_nettype wire

### hdl/qgpg_back.sv
// Back end: per leg phase, swing/stance split and progress division, output register.
`default_nettype none
module qgpg_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire qgpg_pkg::q_stat_t              q_stat_i,
  input  wire logic [qgpg_pkg::PhaseW-1:0]    pop_data_i,
  output logic                                pop_o,
  input  wire qgpg_pkg::gait_e                mode_i,
  input  wire logic [qgpg_pkg::DutyW-1:0]     duty_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output qgpg_pkg::leg_res_t                  out_res_o,
  output logic                                out_last_o
);

  localparam int PW = qgpg_pkg::PhaseW;

  qgpg_pkg::back_state_e state_q, state_d;
  logic [qgpg_pkg::LegW-1:0]     leg_q, leg_d;
  logic [qgpg_pkg::DivStepW-1:0] step_q, step_d;
  logic                          out_valid_q, out_valid_d;
  logic                          load;

  logic [PW-1:0] base_q, base_d;
  logic [PW-1:0] ph_q, ph_d;
  logic          sw_q, sw_d;
  logic [PW-1:0] rem_q, rem_d;
  logic [PW-1:0] dvs_q, dvs_d;
  logic [PW-1:0] quo_q, quo_d;
  qgpg_pkg::leg_res_t res_q;
  logic          last_q;

  logic [PW-1:0] swing;
  logic [PW-1:0] ph;
  logic          is_sw;
  logic [PW:0]   r;
  logic [PW-1:0] q;

  assign swing = PW'(17'h10000 - {1'b0, duty_i});
  assign ph    = base_q + {qgpg_pkg::leg_quarter(mode_i, leg_q), {(PW-2){1'b0}}};
  assign is_sw = (ph < swing);

  // Restoring division, several quotient bits a cycle; remainder stays below divisor
  always_comb begin
    r = {1'b0, rem_q};
    q = quo_q;
    for (int i = 0; i < qgpg_pkg::DivBitsPerCycle; i++) begin
      r = {r[PW-1:0], 1'b0};
      if (r >= {1'b0, dvs_q}) begin
        r = r - {1'b0, dvs_q};
        q = {q[PW-2:0], 1'b1};
      end else begin
        q = {q[PW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    state_d = state_q;
    leg_d   = leg_q;
    step_d  = step_q;
    base_d  = base_q;
    ph_d    = ph_q;
    sw_d    = sw_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    quo_d   = quo_q;
    pop_o   = 1'b0;
    load    = 1'b0;
    unique case (state_q)
      qgpg_pkg::BK_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o   = 1'b1;
          base_d  = pop_data_i;
          leg_d   = '0;
          state_d = qgpg_pkg::BK_LEG;
        end
      end
      qgpg_pkg::BK_LEG: begin
        ph_d    = ph;
        sw_d    = is_sw;
        rem_d   = is_sw ? ph : ph - swing;
        dvs_d   = is_sw ? swing : duty_i;
        quo_d   = '0;
        step_d  = '0;
        state_d = qgpg_pkg::BK_DIV;
      end
      qgpg_pkg::BK_DIV: begin
        rem_d  = r[PW-1:0];
        quo_d  = q;
        step_d = step_q + 1'b1;
        if (step_q == qgpg_pkg::DivStepW'(qgpg_pkg::DivSteps - 1)) state_d = qgpg_pkg::BK_OUT;
      end
      qgpg_pkg::BK_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          load = 1'b1;
          if (leg_q == qgpg_pkg::LastLeg) begin
            state_d = qgpg_pkg::BK_IDLE;
          end else begin
            leg_d   = leg_q + 1'b1;
            state_d = qgpg_pkg::BK_LEG;
          end
        end
      end
      default: state_d = qgpg_pkg::BK_IDLE;
    endcase
  end

  assign out_valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qgpg_pkg::BK_IDLE;
      leg_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      leg_q       <= leg_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    ph_q   <= ph_d;
    sw_q   <= sw_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quo_q  <= quo_d;
    if (load) begin
      res_q.leg         <= leg_q;
      res_q.phase       <= ph_q;
      res_q.swing_now   <= sw_q;
      res_q.swing_frac  <= sw_q ? {1'b0, quo_q} : 17'h10000;
      res_q.stance_frac <= sw_q ? '0 : {1'b0, quo_q};
      last_q            <= (leg_q == qgpg_pkg::LastLeg);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;
  assign out_last_o  = last_q;

endmodule
`default_nettype wire

### hdl/quadruped_gait_phase_generator_core.sv
// Top level of the four-leg gait phase generator: config registers, front, queue, back.
// An input word accepted in idle is registered, split into two partial products, summed to the
//   scaled step; commit updates the accumulator, for a tick once the queue has room.
// The front takes no new word until it is back in idle. The back pops a base phase, then
//   per leg runs load, 4 divider steps of 4 bits and output, which waits for ready.
// Reset: async, active low; gait trot, 1 Hz, duty one half, accumulator 0, queue empty.
`default_nettype none
module quadruped_gait_phase_generator_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Input stream
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  input  wire logic [qgpg_pkg::AmountW-1:0]       s_axis_tdata_i,  // [39:0] amount (signed)
  input  wire logic                               s_axis_tuser_i,  // [0] op: 0 tick, 1 set
  // Output stream
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // [1:0] leg, [17:2] phase, [18] swing flag, [35:19] swing fraction,
  // [52:36] stance fraction, [55:53] zero
  output logic [qgpg_pkg::OutDataW-1:0]           m_axis_tdata_o,
  output logic                                    m_axis_tlast_o,
  // Config write channel
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [qgpg_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [qgpg_pkg::CfgDataW-1:0]      cfg_data_i
);

  // Config registers
  qgpg_pkg::gait_e              mode_q;
  logic [qgpg_pkg::FreqW-1:0]   freq_q;
  logic [qgpg_pkg::DutyW-1:0]   duty_q;
  logic [qgpg_pkg::FreqW-1:0]   freq_eff;
  logic [qgpg_pkg::DutyW-1:0]   duty_eff;

  // Front/queue/back links
  logic                         push;
  logic [qgpg_pkg::PhaseW-1:0]  push_data;
  logic                         pop;
  logic [qgpg_pkg::PhaseW-1:0]  pop_data;
  qgpg_pkg::q_stat_t            q_stat;
  qgpg_pkg::leg_res_t           res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= qgpg_pkg::GAIT_TROT;
      freq_q <= qgpg_pkg::FreqReset;
      duty_q <= qgpg_pkg::DutyReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        qgpg_pkg::CfgGaitMode: mode_q <= qgpg_pkg::gait_e'(cfg_data_i[1:0]);
        qgpg_pkg::CfgFreq:     freq_q <= cfg_data_i[qgpg_pkg::FreqW-1:0];
        qgpg_pkg::CfgDuty:     duty_q <= cfg_data_i[qgpg_pkg::DutyW-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // Frequency floor keeps motion alive; duty clamp keeps both divisors nonzero
  assign freq_eff = (freq_q < qgpg_pkg::FreqMin) ? qgpg_pkg::FreqMin : freq_q;
  assign duty_eff = (duty_q < qgpg_pkg::DutyMin) ? qgpg_pkg::DutyMin :
                    (duty_q > qgpg_pkg::DutyMax) ? qgpg_pkg::DutyMax : duty_q;

  qgpg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_op_i     (s_axis_tuser_i),
    .in_amount_i (s_axis_tdata_i),
    .freq_i      (freq_eff),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Holds base phases of ticks; sets never enter
  qgpg_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  qgpg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .mode_i      (mode_q),
    .duty_i      (duty_eff),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (res),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {{qgpg_pkg::OutPadW{1'b0}}, res};

  // Queue never written while full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_stat.full))
    else $error("base phase queue overflow");

  // Last marker only on the rear right leg
  a_last_leg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (res.leg == qgpg_pkg::LastLeg)))
    else $error("tlast does not match leg index");

  // Swing words carry zero stance fraction
  a_swing_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && res.swing_now) |-> (res.stance_frac == '0))
    else $error("stance fraction nonzero in swing");

  // Stance words carry full swing fraction
  a_stance_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !res.swing_now) |-> (res.swing_frac == 17'h10000))
    else $error("swing fraction not full in stance");

endmodule
`default_nettype wire

### tb/sv/qgpg_leg_checker.sv
// Checker for the gait phase generator: mirrors registers and phase, predicts and compares leg words.
module qgpg_leg_checker
  import qgpg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  input  logic                s_axis_tready_i,
  input  logic [AmountW-1:0]  s_axis_tdata_i,   // [39:0] amount
  input  logic                s_axis_tuser_i,   // [0] op
  input  logic                m_axis_tvalid_i,
  input  logic                m_axis_tready_i,
  input  logic [OutDataW-1:0] m_axis_tdata_i,   // leg, phase, swing flag, swing, stance, pad
  input  logic                m_axis_tlast_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam logic [ProgW-1:0] ProgOne = 17'h10000;

  // Leg word with the last flag on top, tdata layout below it
  typedef struct packed {
    logic              last;
    logic [ProgW-1:0]  stance_prog;
    logic [ProgW-1:0]  swing_prog;
    logic              swing_now;
    logic [PhaseW-1:0] phase;
    logic [LegW-1:0]   leg;
  } leg_word_t;

  gait_e             cfg_gait;
  logic [FreqW-1:0]  cfg_freq;
  logic [DutyW-1:0]  cfg_duty;
  logic [AccW-1:0]   stride_phase;
  leg_word_t         leg_words_q[$];
  int                n_fail = 0;
  int                n_pending = 0;

  assign fail_count_o = n_fail;
  assign pending_o    = n_pending;

  // Phase step as a Q0.32 fraction of a stride: amount * freq is in units of 2^-36 stride, drop 4 bits
  function automatic logic [AccW-1:0] stride_delta(input logic [AmountW-1:0] amt);
    logic [63:0] amt_ext;
    logic [63:0] freq_ext;
    logic [63:0] prod;
    amt_ext  = {{(64 - AmountW){amt[AmountW-1]}}, amt};
    freq_ext = (cfg_freq < FreqMin) ? 64'(FreqMin) : 64'(cfg_freq);
    prod     = amt_ext * freq_ext;
    return prod[AccW+3:4];
  endfunction

  // Quarter-cycle offset per leg, FL in the top pair
  function automatic logic [1:0] leg_offset(input gait_e g, input int leg);
    logic [7:0] row;
    case (g)
      GAIT_WALK:  row = 8'b00_10_11_01;
      GAIT_TROT:  row = 8'b00_10_10_00;
      GAIT_PACE:  row = 8'b00_10_00_10;
      GAIT_BOUND: row = 8'b00_00_10_10;
      default:    row = 8'b0;
    endcase
    return row[7 - 2 * leg -: 2];
  endfunction

  task automatic queue_leg_words();
    logic [DutyW-1:0]  duty;
    logic [ProgW-1:0]  swing;
    logic [PhaseW-1:0] ph;
    logic [32:0]       num;
    leg_word_t         w;
    duty = cfg_duty;
    if (duty < DutyMin) duty = DutyMin;
    if (duty > DutyMax) duty = DutyMax;
    swing = ProgOne - {1'b0, duty};
    for (int i = 0; i < NumLegs; i++) begin
      ph         = stride_phase[AccW-1:AccW-PhaseW] + {leg_offset(cfg_gait, i), 14'd0};
      w.leg      = LegW'(i);
      w.phase    = ph;
      w.last     = (i == NumLegs - 1);
      if ({1'b0, ph} < swing) begin
        w.swing_now   = 1'b1;
        num           = {1'b0, ph, 16'd0};
        w.swing_prog  = ProgW'(num / {16'd0, swing});
        w.stance_prog = '0;
      end else begin
        w.swing_now   = 1'b0;
        w.swing_prog  = ProgOne;
        num           = {({1'b0, ph} - swing), 16'd0};
        w.stance_prog = ProgW'(num / {17'd0, duty});
      end
      leg_words_q.push_back(w);
    end
  endtask

  task automatic check_field(input string name, input logic [ProgW-1:0] want,
                             input logic [ProgW-1:0] got);
    if (want !== got) begin
      n_fail++;
      $display("%0t: leg word %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic compare_leg_word();
    leg_word_t want;
    leg_word_t got;
    got = {m_axis_tlast_i, m_axis_tdata_i[ResW-1:0]};
    check_field("pad", '0, ProgW'(m_axis_tdata_i[OutDataW-1:ResW]));
    if (leg_words_q.size() == 0) begin
      n_fail++;
      $display("%0t: unexpected leg word, expected none, got %h", $time, got);
      return;
    end
    want = leg_words_q.pop_front();
    check_field("leg", ProgW'(want.leg), ProgW'(got.leg));
    check_field("phase", ProgW'(want.phase), ProgW'(got.phase));
    check_field("swing flag", ProgW'(want.swing_now), ProgW'(got.swing_now));
    check_field("swing fraction", want.swing_prog, got.swing_prog);
    check_field("stance fraction", want.stance_prog, got.stance_prog);
    check_field("last", ProgW'(want.last), ProgW'(got.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_gait     = GAIT_TROT;
      cfg_freq     = FreqReset;
      cfg_duty     = DutyReset;
      stride_phase = '0;
      leg_words_q.delete();
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) compare_leg_word();
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgGaitMode: cfg_gait = gait_e'(cfg_data_i[1:0]);
          CfgFreq:     cfg_freq = cfg_data_i[FreqW-1:0];
          CfgDuty:     cfg_duty = cfg_data_i[DutyW-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (op_e'(s_axis_tuser_i) == OP_SET) begin
          stride_phase = stride_delta(s_axis_tdata_i);
        end else begin
          stride_phase = stride_phase + stride_delta(s_axis_tdata_i);
          queue_leg_words();
        end
      end
    end
    n_pending = leg_words_q.size();
  end

endmodule

### tb/sv/quadruped_gait_phase_generator_core_tb.sv
// Testbench top for the gait phase generator: stimulus, stream pacing, watchdog and verdict.
module quadruped_gait_phase_generator_core_tb;
  import qgpg_pkg::*;

  localparam int HalfPeriod    = 5;
  localparam int ResetCycles   = 7;
  localparam int SettleCycles  = 40;    // covers the front's accumulator update after a set
  localparam int WatchdogLimit = 2000;  // quiet cycles before the run is ended
  localparam int SegItems      = 19;
  localparam int Segments      = 4;

  // Index past the register list, must be ignored
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  localparam logic [AmountW-1:0] AmountMax = {1'b0, {(AmountW-1){1'b1}}};
  localparam logic [AmountW-1:0] AmountMin = {1'b1, {(AmountW-1){1'b0}}};

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                s_valid = 1'b0;
  logic                s_ready;
  logic [AmountW-1:0]  s_data = '0;
  logic                s_user = OP_TICK;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [OutDataW-1:0] m_data;
  logic                m_last;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  bit                  idle_on = 1'b1;   // random gaps on both streams
  int                  fail_count;
  int                  pending;

  always #HalfPeriod clk = ~clk;

  quadruped_gait_phase_generator_core i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  qgpg_leg_checker i_chk (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .m_axis_tlast_i  (m_last),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // Called and returns at a falling edge. Valid stays high into the next word
  // unless a gap is drawn, so it is never lowered and raised in one step.
  task automatic send_word(input op_e op, input logic [AmountW-1:0] amt);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= amt;
    s_user  <= op;
    do @(posedge clk); while (!s_ready);
    @(negedge clk);
  endtask

  // One register write; valid drops for a cycle before the next write
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Stop sending, let every expected leg word arrive, then let the front settle
  task automatic drain();
    s_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Mostly sub-cycle steps of either sign, now and then a full-range word
  function automatic logic [AmountW-1:0] random_amount();
    logic [AmountW-1:0] v;
    if ($urandom_range(0, 4) == 0) begin
      v = {8'($urandom), 32'($urandom)};
    end else begin
      v = AmountW'($urandom_range(0, 1 << 19));
      if ($urandom_range(0, 1) == 1) v = -v;
    end
    return v;
  endfunction

  // All three registers in a rotated order, upper data bits random, now and then the unused index too
  task automatic random_config();
    logic [CfgDataW-1:0] freq;
    int                  start;
    case ($urandom_range(0, 3))
      0:       freq = CfgDataW'($urandom_range(0, 80));
      1:       freq = CfgDataW'($urandom_range(32768, 196608));
      2:       freq = CfgDataW'($urandom);
      default: freq = '1;
    endcase
    start = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++) begin
      case ((start + i) % 3)
        0:       write_reg(CfgGaitMode, CfgDataW'($urandom));
        1:       write_reg(CfgFreq, freq);
        default: write_reg(CfgDuty, CfgDataW'($urandom));
      endcase
    end
    if ($urandom_range(0, 1) == 1) write_reg(CfgUnused, CfgDataW'($urandom));
  endtask

  // Downstream ready: random stall bursts between ready runs
  initial begin : sink_pacing
    int span;
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        m_ready <= 1'b0;
        span = $urandom_range(1, 15);
      end else begin
        m_ready <= 1'b1;
        span = $urandom_range(1, 12);
      end
      repeat (span) @(negedge clk);
    end
  end

  // Ends the run once nothing moves on any channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    op_e op;
    repeat (ResetCycles) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: trot, 1 Hz, half duty. At 1 Hz one amount unit moves
    // the leg phase by 1/16 LSB, so 16 * 32768 lands on the swing/stance edge.
    send_word(OP_TICK, '0);
    send_word(OP_TICK, AmountW'(1));
    send_word(OP_SET, AmountW'(524288));
    send_word(OP_TICK, '0);                 // first stance phase
    send_word(OP_TICK, -AmountW'(16));      // last swing phase, backward step
    send_word(OP_TICK, AmountMax);
    send_word(OP_TICK, AmountMin);
    send_word(OP_TICK, '1);
    send_word(OP_SET, '1);                  // negative start time wraps
    send_word(OP_TICK, '0);
    drain();

    // Walk via data with upper bits set; frequency and duty below their floors
    write_reg(CfgGaitMode, 24'hFFFFFC);
    write_reg(CfgFreq, '0);
    write_reg(CfgDuty, '0);
    send_word(OP_TICK, 40'h55_5555_5555);
    send_word(OP_TICK, 40'hAA_AAAA_AAAA);
    send_word(OP_SET, 40'h12_3456_789A);
    send_word(OP_TICK, AmountW'(1000));
    drain();

    // Out-of-list index, pace, all-ones frequency and duty
    write_reg(CfgUnused, '1);
    write_reg(CfgGaitMode, CfgDataW'(GAIT_PACE));
    write_reg(CfgFreq, '1);
    write_reg(CfgDuty, '1);
    send_word(OP_TICK, AmountW'(1));
    send_word(OP_TICK, '1);
    send_word(OP_TICK, AmountW'(12345));
    send_word(OP_SET, '0);
    send_word(OP_TICK, '0);
    drain();

    // Bound, frequency just under the floor, duty at its lower bound
    write_reg(CfgGaitMode, CfgDataW'(GAIT_BOUND));
    write_reg(CfgFreq, CfgDataW'(FreqMin - 1));
    write_reg(CfgDuty, CfgDataW'(DutyMin));
    send_word(OP_TICK, AmountMax);
    send_word(OP_TICK, AmountW'(1 << 20));
    drain();

    // Frequency at the floor, duty at its upper bound
    write_reg(CfgFreq, CfgDataW'(FreqMin));
    write_reg(CfgDuty, CfgDataW'(DutyMax));
    send_word(OP_TICK, AmountW'(3));
    send_word(OP_SET, AmountW'(32768));
    send_word(OP_TICK, AmountW'(7000));

    // Random segments, each under fresh settings; the last one runs without gaps
    for (int seg = 0; seg < Segments; seg++) begin
      drain();
      idle_on = (seg != Segments - 1);
      random_config();
      for (int n = 0; n < SegItems; n++) begin
        if (seg == 1 && n == SegItems / 2) drain();   // hold off until all legs are out
        op = ($urandom_range(0, 7) == 0) ? OP_SET : OP_TICK;
        send_word(op, random_amount());
      end
    end

    drain();
    if (fail_count == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

### files.f
hdl/qgpg_pkg.sv
hdl/qgpg_front.sv
hdl/qgpg_queue.sv
hdl/qgpg_back.sv
hdl/quadruped_gait_phase_generator_core.sv
tb/sv/qgpg_leg_checker.sv
tb/sv/quadruped_gait_phase_generator_core_tb.sv
